// ===== rtl/cpu_exalu_pkg.sv =====
// Shared types, operation codes and ALU helper functions for the execute stage.
package cpu_exalu_pkg;

  typedef enum logic [5:0] {
    K_NOP = 6'd0,
    K_LDA = 6'd1,  K_LDX = 6'd2,  K_LDY = 6'd3,
    K_STA = 6'd4,  K_STX = 6'd5,  K_STY = 6'd6,
    K_ADC = 6'd7,  K_SBC = 6'd8,
    K_AND = 6'd9,  K_ORA = 6'd10, K_EOR = 6'd11,
    K_CMP = 6'd12, K_CPX = 6'd13, K_CPY = 6'd14,
    K_BIT = 6'd15,
    K_ASL_M = 6'd16, K_LSR_M = 6'd17, K_ROL_M = 6'd18, K_ROR_M = 6'd19,
    K_ASL_A = 6'd20, K_LSR_A = 6'd21, K_ROL_A = 6'd22, K_ROR_A = 6'd23,
    K_INC = 6'd24, K_DEC = 6'd25,
    K_INX = 6'd26, K_INY = 6'd27, K_DEX = 6'd28, K_DEY = 6'd29,
    K_TAX = 6'd30, K_TAY = 6'd31, K_TSX = 6'd32, K_TXA = 6'd33,
    K_TXS = 6'd34, K_TYA = 6'd35,
    K_CLC = 6'd36, K_CLD = 6'd37, K_CLI = 6'd38, K_CLV = 6'd39,
    K_SEC = 6'd40, K_SED = 6'd41, K_SEI = 6'd42,
    K_BCC = 6'd43, K_BCS = 6'd44, K_BEQ = 6'd45, K_BNE = 6'd46,
    K_BMI = 6'd47, K_BPL = 6'd48, K_BVC = 6'd49, K_BVS = 6'd50
  } kind_t;

  // Shift and rotate selector
  typedef enum logic [1:0] {
    SH_ASL = 2'd0,
    SH_LSR = 2'd1,
    SH_ROL = 2'd2,
    SH_ROR = 2'd3
  } shift_op_t;

  // Flag bit positions in the status byte (N V 1 B D I Z C)
  localparam logic [2:0] FLAG_C = 3'd0;
  localparam logic [2:0] FLAG_Z = 3'd1;
  localparam logic [2:0] FLAG_I = 3'd2;
  localparam logic [2:0] FLAG_D = 3'd3;
  localparam logic [2:0] FLAG_V = 3'd6;
  localparam logic [2:0] FLAG_N = 3'd7;

  localparam logic [7:0] FLAGS_RESET       = 8'h24;
  localparam logic [7:0] STACK_RESET_VALUE = 8'hFF;

  typedef struct packed {
    logic [7:0] res;
    logic       c;
    logic       v;
  } alu_res_t;

  // Update N and Z from a result byte.
  function automatic logic [7:0] set_nz(input logic [7:0] f, input logic [7:0] v);
    logic [7:0] o;
    o         = f;
    o[FLAG_N] = v[7];
    o[FLAG_Z] = (v == 8'h00);
    return o;
  endfunction

  // Add with carry; decimal mode applies the nibble correction.
  function automatic alu_res_t adc_op(input logic [7:0] a, input logic [7:0] m,
                                      input logic c, input logic d);
    alu_res_t   o;
    logic [8:0] bin;
    logic [4:0] lo;
    logic [5:0] hi;
    bin = {1'b0, a} + {1'b0, m} + {8'b0, c};
    lo  = {1'b0, a[3:0]} + {1'b0, m[3:0]} + {4'b0, c};
    hi  = {2'b0, a[7:4]} + {2'b0, m[7:4]};
    if (lo > 5'h09) begin
      lo = {1'b0, lo[3:0] + 4'h6};
      hi = hi + 6'd1;
    end
    if (hi > 6'h09) begin
      hi = hi + 6'h6;
    end
    if (d) begin
      o.res = {hi[3:0], lo[3:0]};
      o.c   = (hi > 6'd15);
    end else begin
      o.res = bin[7:0];
      o.c   = bin[8];
    end
    o.v = ~(a[7] ^ m[7]) & (a[7] ^ o.res[7]);
    return o;
  endfunction

  // Subtract with borrow; C and V always come from the binary difference.
  function automatic alu_res_t sbc_op(input logic [7:0] a, input logic [7:0] m,
                                      input logic c, input logic d);
    alu_res_t   o;
    logic       b;
    logic [8:0] bin;
    logic [7:0] lo;
    logic [7:0] hi;
    b   = ~c;
    bin = {1'b0, a} - {1'b0, m} - {8'b0, b};
    o.v = (a[7] ^ m[7]) & (a[7] ^ bin[7]);
    o.c = ~bin[8];
    lo  = {4'b0, a[3:0]} - {4'b0, m[3:0]} - {7'b0, b};
    hi  = {4'b0, a[7:4]} - {4'b0, m[7:4]};
    if (lo > 8'h09) begin
      lo = {4'b0, lo[3:0] - 4'h6};
      hi = hi - 8'd1;
    end
    if (hi > 8'h09) begin
      hi = {4'b0, hi[3:0] - 4'h6};
    end
    o.res = d ? {hi[3:0], lo[3:0]} : bin[7:0];
    return o;
  endfunction

  // Shift or rotate one byte; returns {carry out, result}.
  function automatic logic [8:0] shift_op(input shift_op_t op, input logic [7:0] v,
                                          input logic cin);
    logic [8:0] o;
    case (op)
      SH_ASL:  o = {v[7], v[6:0], 1'b0};
      SH_LSR:  o = {v[0], 1'b0, v[7:1]};
      SH_ROL:  o = {v[7], v[6:0], cin};
      SH_ROR:  o = {v[0], cin, v[7:1]};
      default: o = {cin, v};
    endcase
    return o;
  endfunction

endpackage

// ===== rtl/cpu6502_execute_alu.sv =====
// Execute stage: register file, ALU, flag logic and branch test of a 6502-style core.
// Each beat passes the input register, then the result register; the ALU and flag update
//   sit between the two.
// Throughput: one beat per cycle unless out_ready stalls, set by the A/X/Y/P update loop.
// Reset (synchronous, rst_n low): A, X, Y clear, flags load 0x24, stack_reset loads 0xFF.
//   The stack pointer loads from stack_reset in the first cycle after reset; no input beat
//   is taken in that cycle.
module cpu6502_execute_alu (
  input  logic                      clk,
  input  logic                      rst_n,
  // configuration write channel
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [7:0]                cfg_stack_reset,
  // input channel
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [5:0]                in_kind,
  input  logic [7:0]                in_operand_value,
  // result channel
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [7:0]                out_write_value,
  output logic                      out_write_enable,
  output logic                      out_branch_taken,
  output logic [7:0]                out_flags_value,
  output logic [7:0]                out_acc_value,
  output logic [7:0]                out_index_x_value,
  output logic [7:0]                out_index_y_value
);
  import cpu_exalu_pkg::*;

  // configuration and architectural state
  logic [7:0] stack_reset_r;
  logic       sp_load_r;
  logic [7:0] acc_r, acc_nxt;
  logic [7:0] x_r, x_nxt;
  logic [7:0] y_r, y_nxt;
  logic [7:0] sp_r, sp_nxt;
  logic [7:0] flags_r, flags_nxt;

  // input register
  logic       s1_valid_r;
  kind_t      s1_kind_r;
  logic [7:0] s1_operand_r;

  // result register
  logic       out_valid_r;
  logic [7:0] out_wv_r, wv_nxt;
  logic       out_we_r, we_nxt;
  logic       out_br_r, br_nxt;
  logic [7:0] out_status_r;
  logic [7:0] out_acc_r;
  logic [7:0] out_x_r;
  logic [7:0] out_y_r;

  logic       s1_adv;
  logic       in_beat;
  alu_res_t   adc_res;
  alu_res_t   sbc_res;
  logic [8:0] sh_m;
  logic [8:0] sh_a;

  // The result slot frees when empty or when its beat is taken this cycle.
  assign s1_adv    = ~out_valid_r | out_ready;
  assign in_ready  = ~sp_load_r & (~s1_valid_r | s1_adv);
  assign in_beat   = in_valid & in_ready;
  assign cfg_ready = 1'b1;

  // Arithmetic units see the held item and current state.
  assign adc_res = adc_op(acc_r, s1_operand_r, flags_r[FLAG_C], flags_r[FLAG_D]);
  assign sbc_res = sbc_op(acc_r, s1_operand_r, flags_r[FLAG_C], flags_r[FLAG_D]);
  assign sh_m    = shift_op(shift_op_t'(s1_kind_r[1:0]), s1_operand_r, flags_r[FLAG_C]);
  assign sh_a    = shift_op(shift_op_t'(s1_kind_r[1:0]), acc_r, flags_r[FLAG_C]);

  // Next state and result for the item held in the input register.
  always_comb begin
    acc_nxt   = acc_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    sp_nxt    = sp_r;
    flags_nxt = flags_r;
    wv_nxt    = 8'h00;
    we_nxt    = 1'b0;
    br_nxt    = 1'b0;
    case (s1_kind_r)
      K_LDA: begin acc_nxt = s1_operand_r; flags_nxt = set_nz(flags_r, s1_operand_r); end
      K_LDX: begin x_nxt = s1_operand_r; flags_nxt = set_nz(flags_r, s1_operand_r); end
      K_LDY: begin y_nxt = s1_operand_r; flags_nxt = set_nz(flags_r, s1_operand_r); end
      K_STA: begin wv_nxt = acc_r; we_nxt = 1'b1; end
      K_STX: begin wv_nxt = x_r; we_nxt = 1'b1; end
      K_STY: begin wv_nxt = y_r; we_nxt = 1'b1; end
      K_ADC: begin
        acc_nxt           = adc_res.res;
        flags_nxt         = set_nz(flags_r, adc_res.res);
        flags_nxt[FLAG_C] = adc_res.c;
        flags_nxt[FLAG_V] = adc_res.v;
      end
      K_SBC: begin
        acc_nxt           = sbc_res.res;
        flags_nxt         = set_nz(flags_r, sbc_res.res);
        flags_nxt[FLAG_C] = sbc_res.c;
        flags_nxt[FLAG_V] = sbc_res.v;
      end
      K_AND: begin
        acc_nxt   = acc_r & s1_operand_r;
        flags_nxt = set_nz(flags_r, acc_r & s1_operand_r);
      end
      K_ORA: begin
        acc_nxt   = acc_r | s1_operand_r;
        flags_nxt = set_nz(flags_r, acc_r | s1_operand_r);
      end
      K_EOR: begin
        acc_nxt   = acc_r ^ s1_operand_r;
        flags_nxt = set_nz(flags_r, acc_r ^ s1_operand_r);
      end
      K_CMP: begin
        flags_nxt         = set_nz(flags_r, acc_r - s1_operand_r);
        flags_nxt[FLAG_C] = (acc_r >= s1_operand_r);
      end
      K_CPX: begin
        flags_nxt         = set_nz(flags_r, x_r - s1_operand_r);
        flags_nxt[FLAG_C] = (x_r >= s1_operand_r);
      end
      K_CPY: begin
        flags_nxt         = set_nz(flags_r, y_r - s1_operand_r);
        flags_nxt[FLAG_C] = (y_r >= s1_operand_r);
      end
      K_BIT: begin
        flags_nxt[FLAG_N] = s1_operand_r[7];
        flags_nxt[FLAG_V] = s1_operand_r[6];
        flags_nxt[FLAG_Z] = ((acc_r & s1_operand_r) == 8'h00);
      end
      K_ASL_M, K_LSR_M, K_ROL_M, K_ROR_M: begin
        wv_nxt            = sh_m[7:0];
        we_nxt            = 1'b1;
        flags_nxt         = set_nz(flags_r, sh_m[7:0]);
        flags_nxt[FLAG_C] = sh_m[8];
      end
      K_ASL_A, K_LSR_A, K_ROL_A, K_ROR_A: begin
        acc_nxt           = sh_a[7:0];
        flags_nxt         = set_nz(flags_r, sh_a[7:0]);
        flags_nxt[FLAG_C] = sh_a[8];
      end
      K_INC: begin
        wv_nxt    = s1_operand_r + 8'd1;
        we_nxt    = 1'b1;
        flags_nxt = set_nz(flags_r, s1_operand_r + 8'd1);
      end
      K_DEC: begin
        wv_nxt    = s1_operand_r - 8'd1;
        we_nxt    = 1'b1;
        flags_nxt = set_nz(flags_r, s1_operand_r - 8'd1);
      end
      K_INX: begin x_nxt = x_r + 8'd1; flags_nxt = set_nz(flags_r, x_r + 8'd1); end
      K_INY: begin y_nxt = y_r + 8'd1; flags_nxt = set_nz(flags_r, y_r + 8'd1); end
      K_DEX: begin x_nxt = x_r - 8'd1; flags_nxt = set_nz(flags_r, x_r - 8'd1); end
      K_DEY: begin y_nxt = y_r - 8'd1; flags_nxt = set_nz(flags_r, y_r - 8'd1); end
      K_TAX: begin x_nxt = acc_r; flags_nxt = set_nz(flags_r, acc_r); end
      K_TAY: begin y_nxt = acc_r; flags_nxt = set_nz(flags_r, acc_r); end
      K_TSX: begin x_nxt = sp_r; flags_nxt = set_nz(flags_r, sp_r); end
      K_TXA: begin acc_nxt = x_r; flags_nxt = set_nz(flags_r, x_r); end
      K_TXS: sp_nxt = x_r;   // TXS leaves the flags alone
      K_TYA: begin acc_nxt = y_r; flags_nxt = set_nz(flags_r, y_r); end
      K_CLC: flags_nxt[FLAG_C] = 1'b0;
      K_CLD: flags_nxt[FLAG_D] = 1'b0;
      K_CLI: flags_nxt[FLAG_I] = 1'b0;
      K_CLV: flags_nxt[FLAG_V] = 1'b0;
      K_SEC: flags_nxt[FLAG_C] = 1'b1;
      K_SED: flags_nxt[FLAG_D] = 1'b1;
      K_SEI: flags_nxt[FLAG_I] = 1'b1;
      K_BCC: br_nxt = ~flags_r[FLAG_C];
      K_BCS: br_nxt = flags_r[FLAG_C];
      K_BEQ: br_nxt = flags_r[FLAG_Z];
      K_BNE: br_nxt = ~flags_r[FLAG_Z];
      K_BMI: br_nxt = flags_r[FLAG_N];
      K_BPL: br_nxt = ~flags_r[FLAG_N];
      K_BVC: br_nxt = ~flags_r[FLAG_V];
      K_BVS: br_nxt = flags_r[FLAG_V];
      default: ;   // NOP and unassigned codes change nothing
    endcase
  end

  // Control and architectural state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stack_reset_r <= STACK_RESET_VALUE;
      sp_load_r     <= 1'b1;
      acc_r         <= 8'h00;
      x_r           <= 8'h00;
      y_r           <= 8'h00;
      sp_r          <= STACK_RESET_VALUE;
      flags_r       <= FLAGS_RESET;
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        stack_reset_r <= cfg_stack_reset;
      end
      // Load the stack pointer once, from the value the register holds after reset.
      sp_load_r <= 1'b0;
      if (sp_load_r) begin
        sp_r <= stack_reset_r;
      end
      // Advance the held item: commit its state update and fill the result slot.
      if (s1_valid_r && s1_adv) begin
        acc_r   <= acc_nxt;
        x_r     <= x_nxt;
        y_r     <= y_nxt;
        sp_r    <= sp_nxt;
        flags_r <= flags_nxt;
      end
      if (in_beat) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // Payload registers hold without reset.
  always_ff @(posedge clk) begin
    if (in_beat) begin
      s1_kind_r    <= kind_t'(in_kind);
      s1_operand_r <= in_operand_value;
    end
    if (s1_valid_r && s1_adv) begin
      out_wv_r     <= wv_nxt;
      out_we_r     <= we_nxt;
      out_br_r     <= br_nxt;
      out_status_r <= flags_nxt;
      out_acc_r    <= acc_nxt;
      out_x_r      <= x_nxt;
      out_y_r      <= y_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_write_value   = out_wv_r;
  assign out_write_enable  = out_we_r;
  assign out_branch_taken  = out_br_r;
  assign out_flags_value   = out_status_r;
  assign out_acc_value     = out_acc_r;
  assign out_index_x_value = out_x_r;
  assign out_index_y_value = out_y_r;

  // Bits 5 and 4 of the flag byte never move.
  a_flag_fixed_bits: assert property (@(posedge clk) disable iff (!rst_n)
    flags_r[5] && !flags_r[4])
    else $error("flag byte bit 5 or 4 changed");

  // A result beat never both writes memory and reports a branch.
  a_we_br_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_we_r && out_br_r))
    else $error("write enable and branch taken both set");

  // Write data reads zero whenever no write is requested.
  a_wv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_we_r) |-> (out_wv_r == 8'h00))
    else $error("write value nonzero without write enable");

  // An accepted input beat always lands in the input register.
  a_in_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |=> s1_valid_r)
    else $error("accepted input beat lost");

  // No input beat is taken while the stack pointer loads after reset.
  a_no_beat_on_load: assert property (@(posedge clk) disable iff (!rst_n)
    sp_load_r |-> !in_ready)
    else $error("input accepted during stack pointer load");

endmodule

// ===== tb/cpu6502_execute_alu_test.sv =====
// Self-checking testbench for the 6502-style execute stage: random and directed beats.
module cpu6502_execute_alu_test;
  import cpu_exalu_pkg::*;

  // One predicted result beat, field for field as the result channel carries it
  typedef struct packed {
    logic [7:0] write_value;
    logic       write_enable;
    logic       branch_taken;
    logic [7:0] status;
    logic [7:0] acc;
    logic [7:0] idx_x;
    logic [7:0] idx_y;
  } exec_result_t;

  // What the feeder does with the head of the instruction stream
  typedef enum logic [1:0] {
    STEP_INSTR,
    STEP_SET_SP_RESET,
    STEP_QUIESCE
  } step_kind_t;

  typedef struct {
    step_kind_t  what;
    logic [5:0]  kind;
    logic [7:0]  operand;
    int unsigned gap;
  } stream_entry_t;

  localparam int SETTLE_CYCLES = 4;     // settle time covering the two stages, input and result register
  localparam int LONG_HOLD     = 150;   // receiver back-pressure long enough to fill the block

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_stack_reset = 8'h00;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [5:0] in_kind = 6'd0;
  logic [7:0] in_operand_value = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_write_value;
  logic       out_write_enable;
  logic       out_branch_taken;
  logic [7:0] out_flags_value;
  logic [7:0] out_acc_value;
  logic [7:0] out_index_x_value;
  logic [7:0] out_index_y_value;

  // Architectural state as the testbench tracks it. A stack_reset write only
  // reaches the stack pointer at a reset, and reset is applied just once, so the
  // stack pointer never reloads from it.
  logic [7:0] arch_a;
  logic [7:0] arch_x;
  logic [7:0] arch_y;
  logic [7:0] arch_sp;
  logic [7:0] arch_p;

  stream_entry_t instr_stream[$];
  exec_result_t  retire_q[$];

  int  calm_sends = 0;
  int  calm_recvs = 0;
  int  idle_cycles = 0;
  int  settle_left = 0;
  int  stall_left = 0;
  int  retired = 0;
  int  mismatches = 0;
  bit  feed_done = 1'b0;

  cpu6502_execute_alu uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_stack_reset   (cfg_stack_reset),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_kind           (in_kind),
    .in_operand_value  (in_operand_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_write_value   (out_write_value),
    .out_write_enable  (out_write_enable),
    .out_branch_taken  (out_branch_taken),
    .out_flags_value   (out_flags_value),
    .out_acc_value     (out_acc_value),
    .out_index_x_value (out_index_x_value),
    .out_index_y_value (out_index_y_value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Update N and Z from a result byte and pass the byte through
  function automatic logic [7:0] track_nz(input logic [7:0] v);
    arch_p[FLAG_N] = v[7];
    arch_p[FLAG_Z] = (v == 8'h00);
    return v;
  endfunction

  // Execute one instruction on the tracked state and return the result beat it retires
  function automatic exec_result_t execute_instr(input logic [5:0] k, input logic [7:0] m);
    exec_result_t beat;
    logic [7:0]   res8;
    logic [7:0]   src;
    logic [7:0]   cmp_reg;
    logic         cin;
    int           a_i;
    int           m_i;
    int           lo;
    int           hi;
    int           sum;
    int           diff;
    int           borrow;
    beat = '0;
    a_i  = int'(arch_a);
    m_i  = int'(m);
    case (k)
      K_LDA: arch_a = track_nz(m);
      K_LDX: arch_x = track_nz(m);
      K_LDY: arch_y = track_nz(m);
      K_STA: begin
        beat.write_value  = arch_a;
        beat.write_enable = 1'b1;
      end
      K_STX: begin
        beat.write_value  = arch_x;
        beat.write_enable = 1'b1;
      end
      K_STY: begin
        beat.write_value  = arch_y;
        beat.write_enable = 1'b1;
      end
      K_ADC: begin
        if (arch_p[FLAG_D]) begin
          // decimal: correct each nibble past 9 by 6, carry one into the high nibble
          lo = a_i % 16 + m_i % 16 + int'(arch_p[FLAG_C]);
          hi = a_i / 16 + m_i / 16;
          if (lo > 9) begin
            lo = (lo + 6) & 15;
            hi = hi + 1;
          end
          if (hi > 9) begin
            hi = hi + 6;
          end
          arch_p[FLAG_C] = (hi > 15);
          res8 = {hi[3:0], lo[3:0]};
        end else begin
          sum = a_i + m_i + int'(arch_p[FLAG_C]);
          arch_p[FLAG_C] = (sum > 255);
          res8 = sum[7:0];
        end
        arch_p[FLAG_V] = (arch_a[7] == m[7]) && (arch_a[7] != res8[7]);
        arch_a = track_nz(res8);
      end
      K_SBC: begin
        // C and V always come from the binary difference
        borrow = arch_p[FLAG_C] ? 0 : 1;
        diff   = a_i - m_i - borrow;
        res8   = diff[7:0];
        arch_p[FLAG_V] = (arch_a[7] != m[7]) && (arch_a[7] != res8[7]);
        arch_p[FLAG_C] = (a_i >= m_i + borrow);
        if (arch_p[FLAG_D]) begin
          lo = (a_i % 16 - m_i % 16 - borrow) & 255;
          hi = (a_i / 16 - m_i / 16) & 255;
          if (lo > 9) begin
            lo = (lo - 6) & 15;
            hi = (hi - 1) & 255;
          end
          if (hi > 9) begin
            hi = (hi - 6) & 15;
          end
          res8 = {hi[3:0], lo[3:0]};
        end
        arch_a = track_nz(res8);
      end
      K_AND: arch_a = track_nz(arch_a & m);
      K_ORA: arch_a = track_nz(arch_a | m);
      K_EOR: arch_a = track_nz(arch_a ^ m);
      K_CMP, K_CPX, K_CPY: begin
        // compares touch only N, Z and C, against their own register
        cmp_reg = (k == K_CMP) ? arch_a : (k == K_CPX) ? arch_x : arch_y;
        arch_p[FLAG_C] = (cmp_reg >= m);
        res8 = cmp_reg - m;
        void'(track_nz(res8));
      end
      K_BIT: begin
        arch_p[FLAG_N] = m[7];
        arch_p[FLAG_V] = m[6];
        arch_p[FLAG_Z] = ((arch_a & m) == 8'h00);
      end
      K_ASL_M, K_LSR_M, K_ROL_M, K_ROR_M,
      K_ASL_A, K_LSR_A, K_ROL_A, K_ROR_A: begin
        src = (k < K_ASL_A) ? m : arch_a;
        cin = arch_p[FLAG_C];
        case (shift_op_t'(k[1:0]))
          SH_ASL: begin
            res8 = {src[6:0], 1'b0};
            arch_p[FLAG_C] = src[7];
          end
          SH_LSR: begin
            res8 = {1'b0, src[7:1]};
            arch_p[FLAG_C] = src[0];
          end
          SH_ROL: begin
            res8 = {src[6:0], cin};
            arch_p[FLAG_C] = src[7];
          end
          default: begin
            res8 = {cin, src[7:1]};
            arch_p[FLAG_C] = src[0];
          end
        endcase
        res8 = track_nz(res8);
        if (k < K_ASL_A) begin
          beat.write_value  = res8;
          beat.write_enable = 1'b1;
        end else begin
          arch_a = res8;
        end
      end
      K_INC: begin
        res8 = m + 8'd1;
        beat.write_value  = track_nz(res8);
        beat.write_enable = 1'b1;
      end
      K_DEC: begin
        res8 = m - 8'd1;
        beat.write_value  = track_nz(res8);
        beat.write_enable = 1'b1;
      end
      K_INX: arch_x = track_nz(arch_x + 8'd1);
      K_INY: arch_y = track_nz(arch_y + 8'd1);
      K_DEX: arch_x = track_nz(arch_x - 8'd1);
      K_DEY: arch_y = track_nz(arch_y - 8'd1);
      K_TAX: arch_x = track_nz(arch_a);
      K_TAY: arch_y = track_nz(arch_a);
      K_TSX: arch_x = track_nz(arch_sp);
      K_TXA: arch_a = track_nz(arch_x);
      K_TXS: arch_sp = arch_x;
      K_TYA: arch_a = track_nz(arch_y);
      K_CLC: arch_p[FLAG_C] = 1'b0;
      K_CLD: arch_p[FLAG_D] = 1'b0;
      K_CLI: arch_p[FLAG_I] = 1'b0;
      K_CLV: arch_p[FLAG_V] = 1'b0;
      K_SEC: arch_p[FLAG_C] = 1'b1;
      K_SED: arch_p[FLAG_D] = 1'b1;
      K_SEI: arch_p[FLAG_I] = 1'b1;
      K_BCC: beat.branch_taken = !arch_p[FLAG_C];
      K_BCS: beat.branch_taken = arch_p[FLAG_C];
      K_BEQ: beat.branch_taken = arch_p[FLAG_Z];
      K_BNE: beat.branch_taken = !arch_p[FLAG_Z];
      K_BMI: beat.branch_taken = arch_p[FLAG_N];
      K_BPL: beat.branch_taken = !arch_p[FLAG_N];
      K_BVC: beat.branch_taken = !arch_p[FLAG_V];
      K_BVS: beat.branch_taken = arch_p[FLAG_V];
      default: ;  // NOP and the unused codes leave everything alone
    endcase
    beat.status = arch_p;
    beat.acc    = arch_a;
    beat.idx_x  = arch_x;
    beat.idx_y  = arch_y;
    return beat;
  endfunction

  // Queue one instruction beat; the gap before it runs in calm stretches or random
  function automatic void push_instr(input logic [5:0] k, input logic [7:0] m);
    stream_entry_t e;
    e.what    = STEP_INSTR;
    e.kind    = k;
    e.operand = m;
    if (calm_sends > 0) begin
      calm_sends--;
      e.gap = 0;
    end else if ($urandom_range(0, 14) == 0) begin
      calm_sends = $urandom_range(20, 80);
      e.gap = 0;
    end else begin
      e.gap = $urandom_range(0, 9);
    end
    instr_stream.push_back(e);
  endfunction

  function automatic void push_sp_reset(input logic [7:0] v);
    stream_entry_t e;
    e.what    = STEP_SET_SP_RESET;
    e.kind    = K_NOP;
    e.operand = v;
    e.gap     = 0;
    instr_stream.push_back(e);
  endfunction

  function automatic void push_quiesce();
    stream_entry_t e;
    e.what    = STEP_QUIESCE;
    e.kind    = K_NOP;
    e.operand = 8'h00;
    e.gap     = 0;
    instr_stream.push_back(e);
  endfunction

  // Feeder: present instruction and config beats from the stream; predict on each
  // accepted instruction beat. Valid is computed once and assigned once per edge.
  always @(posedge clk) begin : feed
    logic hold_in;
    logic hold_cfg;
    if (!rst_n) begin
      in_valid        <= 1'b0;
      cfg_valid       <= 1'b0;
      arch_a          = 8'h00;
      arch_x          = 8'h00;
      arch_y          = 8'h00;
      arch_sp         = STACK_RESET_VALUE;
      arch_p          = FLAGS_RESET;
      idle_cycles     = 0;
      settle_left     = 0;
    end else begin
      hold_in  = in_valid;
      hold_cfg = cfg_valid;
      if (in_valid && in_ready) begin
        retire_q.push_back(execute_instr(in_kind, in_operand_value));
        hold_in = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        hold_cfg = 1'b0;
      end
      if (!hold_in && !hold_cfg) begin
        if (settle_left > 0) begin
          settle_left--;
        end else if (instr_stream.size() == 0) begin
          feed_done = 1'b1;
        end else begin
          case (instr_stream[0].what)
            STEP_INSTR: begin
              // hold off for the drawn gap, then offer the beat
              if (idle_cycles >= instr_stream[0].gap) begin
                in_kind          <= instr_stream[0].kind;
                in_operand_value <= instr_stream[0].operand;
                hold_in     = 1'b1;
                idle_cycles = 0;
                void'(instr_stream.pop_front());
              end else begin
                idle_cycles++;
              end
            end
            STEP_SET_SP_RESET: begin
              cfg_stack_reset <= instr_stream[0].operand;
              hold_cfg = 1'b1;
              void'(instr_stream.pop_front());
            end
            default: begin
              // pause the sender until every result is back, then let the pipe settle
              if (retire_q.size() == 0) begin
                settle_left = SETTLE_CYCLES;
                void'(instr_stream.pop_front());
              end
            end
          endcase
        end
      end
      in_valid  <= hold_in;
      cfg_valid <= hold_cfg;
    end
  end

  // Collector: check each result beat against the oldest prediction and draw the
  // receiver's stall; twice hold off for a long stretch so the block backs up.
  always @(posedge clk) begin : collect
    exec_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        retired++;
        if (retire_q.size() == 0) begin
          $error("result beat with no instruction outstanding");
          mismatches++;
        end else begin
          want = retire_q.pop_front();
          if (out_write_value !== want.write_value) begin
            $error("write_value: expected %02h, got %02h", want.write_value, out_write_value);
            mismatches++;
          end
          if (out_write_enable !== want.write_enable) begin
            $error("write_enable: expected %0d, got %0d", want.write_enable, out_write_enable);
            mismatches++;
          end
          if (out_branch_taken !== want.branch_taken) begin
            $error("branch_taken: expected %0d, got %0d", want.branch_taken, out_branch_taken);
            mismatches++;
          end
          if (out_flags_value !== want.status) begin
            $error("flags_value: expected %02h, got %02h", want.status, out_flags_value);
            mismatches++;
          end
          if (out_acc_value !== want.acc) begin
            $error("acc_value: expected %02h, got %02h", want.acc, out_acc_value);
            mismatches++;
          end
          if (out_index_x_value !== want.idx_x) begin
            $error("index_x_value: expected %02h, got %02h", want.idx_x, out_index_x_value);
            mismatches++;
          end
          if (out_index_y_value !== want.idx_y) begin
            $error("index_y_value: expected %02h, got %02h", want.idx_y, out_index_y_value);
            mismatches++;
          end
        end
        if (retired == 500 || retired == 1400) begin
          stall_left = LONG_HOLD;
        end else if (calm_recvs > 0) begin
          calm_recvs--;
          stall_left = 0;
        end else if ($urandom_range(0, 14) == 0) begin
          calm_recvs = $urandom_range(20, 80);
          stall_left = 0;
        end else begin
          stall_left = $urandom_range(0, 9);
        end
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_ready <= (stall_left == 0);
    end
  end

  // Build the whole stream, release reset, then wait for the last result beat
  initial begin : stimulus
    logic [5:0] k;
    logic [7:0] m;
    int         pick;

    // let the stack pointer load settle before the first register write
    push_quiesce();
    push_sp_reset(8'h00);

    // decimal add and subtract, including wrap and invalid BCD digits
    push_instr(K_LDA, 8'h99);
    push_instr(K_SED, 8'h00);
    push_instr(K_CLC, 8'h00);
    push_instr(K_ADC, 8'h01);
    push_instr(K_ADC, 8'hFF);
    push_instr(K_SBC, 8'h99);
    push_instr(K_SBC, 8'h0A);
    push_instr(K_CLD, 8'h00);
    // binary add with overflow, then a subtract that does not overflow
    push_instr(K_ADC, 8'h7F);
    push_instr(K_SBC, 8'h80);
    // compares against their own register only
    push_instr(K_CMP, 8'h00);
    push_instr(K_CPX, 8'hFF);
    // LSR carries out of bit 0; ROR pulls the carry in
    push_instr(K_LSR_M, 8'h01);
    push_instr(K_ROR_A, 8'h00);
    // INC and DEC write back across the wrap
    push_instr(K_INC, 8'hFF);
    push_instr(K_DEC, 8'h00);
    // stack pointer starts at its reset value, then follows X
    push_instr(K_TSX, 8'h00);
    push_instr(K_LDX, 8'h00);
    push_instr(K_TXS, 8'h00);
    push_instr(K_TSX, 8'h00);
    push_instr(K_BIT, 8'hC0);
    push_instr(K_BVS, 8'h00);
    push_instr(K_BEQ, 8'h00);
    // top unused code acts as a no-op
    push_instr(6'd63, 8'hFF);
    push_instr(K_STA, 8'h00);

    // three random phases, each opened by a drain and a register write
    for (int phase = 0; phase < 3; phase++) begin
      push_quiesce();
      case (phase)
        0:       push_sp_reset(8'hFF);
        1:       push_sp_reset(8'($urandom_range(1, 254)));
        default: push_sp_reset(8'h80);
      endcase
      for (int n = 0; n < 625; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          k = 6'($urandom_range(51, 63));
        end else if (pick < 22) begin
          k = ($urandom_range(0, 1) == 0) ? K_ADC : K_SBC;
        end else if (pick < 28) begin
          k = ($urandom_range(0, 1) == 0) ? K_SED : K_CLD;
        end else begin
          k = 6'($urandom_range(0, 50));
        end
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          m = 8'h00;
        end else if (pick == 1) begin
          m = 8'hFF;
        end else if (pick < 4) begin
          m = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
        end else begin
          m = 8'($urandom_range(0, 255));
        end
        push_instr(k, m);
      end
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    wait (feed_done);
    while (retire_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES + 4) @(posedge clk);
    if (mismatches == 0 && retire_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run
  initial begin : watchdog
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/cpu_exalu_pkg.sv
rtl/cpu6502_execute_alu.sv
tb/cpu6502_execute_alu_test.sv
